// File: hdl/stl_pkg.sv
package stl_pkg;

    // operation codes
    localparam logic [1:0] FUNC_INSERT     = 2'd0;
    localparam logic [1:0] FUNC_REMOVE     = 2'd1;
    localparam logic [1:0] FUNC_FIND_ID    = 2'd2;
    localparam logic [1:0] FUNC_FIND_EMPTY = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_MISS  = 2'd2;

    // configuration register indexes
    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_FIRST_ID   = 1'b1;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 8;
    localparam int WORD_W   = 64;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 6;
    localparam int TSIZE_W  = 7;
    localparam int CFG_W    = 32;

    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 7'd64;
    localparam logic [ID_W-1:0]    FIRST_ID_RESET = 32'd0;

    // microprogram steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_FETCH    = 3'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH = 3'd1;
    localparam logic [STEP_W-1:0] S_INSERT   = 3'd2;
    localparam logic [STEP_W-1:0] S_REMOVE   = 3'd3;
    localparam logic [STEP_W-1:0] S_ID_READ  = 3'd4;
    localparam logic [STEP_W-1:0] S_ID_CMP   = 3'd5;
    localparam logic [STEP_W-1:0] S_SCAN     = 3'd6;
    localparam logic [STEP_W-1:0] S_EMIT     = 3'd7;

    // datapath actions
    localparam logic [2:0] A_NOP    = 3'd0;
    localparam logic [2:0] A_LATCH  = 3'd1;
    localparam logic [2:0] A_INSERT = 3'd2;
    localparam logic [2:0] A_REMOVE = 3'd3;
    localparam logic [2:0] A_READ   = 3'd4;
    localparam logic [2:0] A_CMP_ID = 3'd5;
    localparam logic [2:0] A_SCAN   = 3'd6;
    localparam logic [2:0] A_EMIT   = 3'd7;

    // jump conditions
    localparam logic [2:0] C_ALWAYS   = 3'd0;
    localparam logic [2:0] C_NOREQ    = 3'd1;
    localparam logic [2:0] C_FUNC     = 3'd2;
    localparam logic [2:0] C_END      = 3'd3;
    localparam logic [2:0] C_HIT      = 3'd4;
    localparam logic [2:0] C_END_FREE = 3'd5;
    localparam logic [2:0] C_OUT_BUSY = 3'd6;

    typedef struct packed {
        logic [2:0]        act;
        logic [2:0]        cond;
        logic [STEP_W-1:0] jump;
        logic [STEP_W-1:0] nxt;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uw;
        unique case (step)
            S_FETCH:    uw = '{A_LATCH,  C_NOREQ,    S_FETCH, S_DISPATCH};
            S_DISPATCH: uw = '{A_NOP,    C_FUNC,     S_FETCH, S_FETCH};
            S_INSERT:   uw = '{A_INSERT, C_ALWAYS,   S_EMIT,  S_EMIT};
            S_REMOVE:   uw = '{A_REMOVE, C_ALWAYS,   S_EMIT,  S_EMIT};
            S_ID_READ:  uw = '{A_READ,   C_END,      S_EMIT,  S_ID_CMP};
            S_ID_CMP:   uw = '{A_CMP_ID, C_HIT,      S_EMIT,  S_ID_READ};
            S_SCAN:     uw = '{A_SCAN,   C_END_FREE, S_EMIT,  S_SCAN};
            S_EMIT:     uw = '{A_EMIT,   C_OUT_BUSY, S_EMIT,  S_FETCH};
        endcase
        return uw;
    endfunction

    // entry step for each operation
    function automatic logic [STEP_W-1:0] dispatch(input logic [FUNC_W-1:0] func);
        logic [STEP_W-1:0] step;
        unique case (func)
            FUNC_INSERT:     step = S_INSERT;
            FUNC_REMOVE:     step = S_REMOVE;
            FUNC_FIND_ID:    step = S_ID_READ;
            FUNC_FIND_EMPTY: step = S_SCAN;
        endcase
        return step;
    endfunction

endpackage

// File: hdl/slot_table_with_id_lookup_unit.sv
// Channel  | Handshake          | Payload
// s_       | s_valid / s_ready  | s_func, s_slot_index, s_record_word, s_search_id
// m_       | m_valid / m_ready  | m_status, m_found_index, m_assigned_id, m_record_out
// cfg_     | cfg_wr_en          | cfg_index, cfg_wdata
//
// Insert and remove go through fetch, dispatch, their own step and emit; emit sets m_valid.
// Find by id reads the id/record memory, then compares, for each slot visited.
// Find empty scans one valid bit per cycle.
// Reset clears all valid bits together; no clearing pass.
// A finished result waits in the output register while the next request is taken;
// the sequencer stalls in its emit step only if that register is still full.
module slot_table_with_id_lookup_unit
    import stl_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int RECORD_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [SLOT_W-1:0]   s_slot_index,
    input  logic [WORD_W-1:0]   s_record_word,
    input  logic [ID_W-1:0]     s_search_id,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [FOUND_W-1:0]  m_found_index,
    output logic [ID_W-1:0]     m_assigned_id,
    output logic [WORD_W-1:0]   m_record_out,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // sequencer
    logic [STEP_W-1:0] pc_reg, pc_next;
    ucode_t            uc;
    logic              take_jump;

    // configuration and table state
    logic [TSIZE_W-1:0]   tsize_reg;
    logic [ID_W-1:0]      id_cnt_reg;
    logic                 valid_reg [DEPTH];
    logic [ID_W-1:0]      id_mem  [DEPTH];
    logic [RECORD_BITS-1:0] rec_mem [DEPTH];
    logic [ID_W-1:0]      id_rd_reg;
    logic [RECORD_BITS-1:0] rec_rd_reg;

    // latched request
    logic [FUNC_W-1:0]      func_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [RECORD_BITS-1:0] rec_reg;
    logic [ID_W-1:0]        sid_reg;

    // working result
    logic [CMP_W-1:0]    ptr_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CMP_W-1:0]    found_reg;
    logic [ID_W-1:0]     assigned_reg;
    logic [WORD_W-1:0]   record_reg;

    // output register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [FOUND_W-1:0]  m_found_reg;
    logic [ID_W-1:0]     m_assigned_reg;
    logic [WORD_W-1:0]   m_record_reg;

    logic [CMP_W-1:0] tsize_ext, eff_size;
    logic [IDX_W-1:0] ptr_idx, slot_idx;
    logic             idx_ok, ptr_end, id_hit, scan_free, out_busy, accept;

    assign tsize_ext = CMP_W'(tsize_reg);
    assign eff_size  = (tsize_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : tsize_ext;
    assign ptr_idx   = ptr_reg[IDX_W-1:0];
    assign slot_idx  = idx_reg[IDX_W-1:0];
    assign idx_ok    = CMP_W'(idx_reg) < eff_size;
    assign ptr_end   = ptr_reg >= eff_size;
    assign id_hit    = valid_reg[ptr_idx] && (id_rd_reg == sid_reg);
    assign scan_free = !ptr_end && !valid_reg[ptr_idx];
    assign out_busy  = m_valid_reg && !m_ready;

    assign uc      = ucode_rom(pc_reg);
    assign s_ready = (uc.act == A_LATCH);
    assign accept  = s_valid && s_ready;

    always_comb begin
        take_jump = 1'b0;
        pc_next   = uc.nxt;
        case (uc.cond)
            C_ALWAYS:   take_jump = 1'b1;
            C_NOREQ:    take_jump = !s_valid;
            C_FUNC:     take_jump = 1'b0;
            C_END:      take_jump = ptr_end;
            C_HIT:      take_jump = id_hit;
            C_END_FREE: take_jump = ptr_end || scan_free;
            C_OUT_BUSY: take_jump = out_busy;
            default:    take_jump = 1'b0;
        endcase
        if (uc.cond == C_FUNC) begin
            pc_next = dispatch(func_reg);
        end else if (take_jump) begin
            pc_next = uc.jump;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= S_FETCH;
            tsize_reg   <= TSIZE_RESET;
            id_cnt_reg  <= FIRST_ID_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            pc_reg <= pc_next;
            if (uc.act == A_INSERT && idx_ok) begin
                valid_reg[slot_idx] <= 1'b1;
                id_cnt_reg          <= id_cnt_reg + 1'b1;
            end else if (cfg_wr_en && cfg_index == CFG_FIRST_ID) begin
                id_cnt_reg <= cfg_wdata[ID_W-1:0];
            end
            if (cfg_wr_en && cfg_index == CFG_TABLE_SIZE) begin
                tsize_reg <= cfg_wdata[TSIZE_W-1:0];
            end
            if (uc.act == A_REMOVE && idx_ok) begin
                valid_reg[slot_idx] <= 1'b0;
            end
            if (uc.act == A_EMIT && !out_busy) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // id and record memories
    always_ff @(posedge aclk) begin
        if (uc.act == A_INSERT && idx_ok) begin
            id_mem[slot_idx]  <= id_cnt_reg;
            rec_mem[slot_idx] <= rec_reg;
        end
        if (uc.act == A_READ) begin
            id_rd_reg  <= id_mem[ptr_idx];
            rec_rd_reg <= rec_mem[ptr_idx];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_func;
            idx_reg      <= s_slot_index;
            rec_reg      <= s_record_word[RECORD_BITS-1:0];
            sid_reg      <= s_search_id;
            ptr_reg      <= '0;
            status_reg   <= STATUS_MISS;
            found_reg    <= '0;
            assigned_reg <= '0;
            record_reg   <= '0;
        end
        unique case (uc.act)
            A_INSERT: begin
                if (idx_ok) begin
                    status_reg   <= STATUS_OK;
                    assigned_reg <= id_cnt_reg;
                end else begin
                    status_reg <= STATUS_RANGE;
                end
            end
            A_REMOVE: begin
                status_reg <= idx_ok ? STATUS_OK : STATUS_RANGE;
            end
            A_CMP_ID: begin
                if (id_hit) begin
                    status_reg <= STATUS_OK;
                    found_reg  <= ptr_reg;
                    record_reg <= WORD_W'(rec_rd_reg);
                end else begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            A_SCAN: begin
                if (scan_free) begin
                    status_reg <= STATUS_OK;
                    found_reg  <= ptr_reg;
                end else if (!ptr_end) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            A_EMIT: begin
                if (!out_busy) begin
                    m_status_reg   <= status_reg;
                    m_found_reg    <= found_reg[FOUND_W-1:0];
                    m_assigned_reg <= assigned_reg;
                    m_record_reg   <= record_reg;
                end
            end
            A_NOP, A_LATCH, A_READ: begin
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_index = m_found_reg;
    assign m_assigned_id = m_assigned_reg;
    assign m_record_out  = m_record_reg;

`ifndef ASSERT_OFF
    a_insert_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.act == A_INSERT && idx_ok) |=> valid_reg[slot_idx])
        else $error("inserted slot not marked valid");

    a_insert_steps_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.act == A_INSERT && idx_ok && !cfg_wr_en)
            |=> id_cnt_reg == $past(id_cnt_reg) + 32'd1)
        else $error("id counter did not advance by one on insert");

    a_id_hit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.act == A_CMP_ID && id_hit)
            |=> status_reg == STATUS_OK && found_reg == $past(ptr_reg)
                && pc_reg == S_EMIT)
        else $error("id hit not captured");

    a_scan_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (uc.act == A_SCAN && scan_free)
            |=> !valid_reg[found_reg[IDX_W-1:0]] && status_reg == STATUS_OK)
        else $error("empty search returned an occupied slot");
`endif

endmodule

// File: tb/sv/slot_table_checker.sv
module slot_table_checker
    import stl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [FUNC_W-1:0]   s_func,
    input  logic [SLOT_W-1:0]   s_slot_index,
    input  logic [WORD_W-1:0]   s_record_word,
    input  logic [ID_W-1:0]     s_search_id,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [FOUND_W-1:0]  m_found_index,
    input  logic [ID_W-1:0]     m_assigned_id,
    input  logic [WORD_W-1:0]   m_record_out,

    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,

    output int                  fail_count,
    output int                  pending_count
);

    localparam int SLOTS = 64;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic [ID_W-1:0]   sid;
    } table_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found;
        logic [ID_W-1:0]     assigned;
        logic [WORD_W-1:0]   word;
    } table_resp_t;

    // shadow copy of the table and its registers
    logic                  occupied [SLOTS];
    logic [ID_W-1:0]       slot_id  [SLOTS];
    logic [WORD_W-1:0]     slot_word[SLOTS];
    logic [TSIZE_W-1:0]    size_reg;
    logic [ID_W-1:0]       start_id;
    logic [ID_W-1:0]       next_id;

    table_resp_t           expected_resps[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic table_resp_t apply_request(input table_req_t rq);
        table_resp_t r;
        int          lim;
        logic        hit;
        r.status   = STATUS_MISS;
        r.found    = '0;
        r.assigned = '0;
        r.word     = '0;
        hit        = 1'b0;
        lim = (int'(size_reg) > SLOTS) ? SLOTS : int'(size_reg);
        case (rq.func)
            FUNC_INSERT: begin
                if (int'(rq.slot) < lim) begin
                    occupied[rq.slot]  = 1'b1;
                    slot_id[rq.slot]   = next_id;
                    slot_word[rq.slot] = rq.word;
                    r.assigned         = next_id;
                    next_id            = next_id + 1;
                    r.status           = STATUS_OK;
                end else begin
                    r.status = STATUS_RANGE;
                end
            end
            FUNC_REMOVE: begin
                if (int'(rq.slot) < lim) begin
                    occupied[rq.slot] = 1'b0;
                    r.status          = STATUS_OK;
                end else begin
                    r.status = STATUS_RANGE;
                end
            end
            FUNC_FIND_ID: begin
                // lowest valid slot wins
                for (int i = 0; i < lim; i++) begin
                    if (!hit && occupied[i] && slot_id[i] == rq.sid) begin
                        hit      = 1'b1;
                        r.status = STATUS_OK;
                        r.found  = FOUND_W'(i);
                        r.word   = slot_word[i];
                    end
                end
            end
            FUNC_FIND_EMPTY: begin
                for (int i = 0; i < lim; i++) begin
                    if (!hit && !occupied[i]) begin
                        hit      = 1'b1;
                        r.status = STATUS_OK;
                        r.found  = FOUND_W'(i);
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        table_req_t  req;
        table_resp_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                occupied[i] = 1'b0;
            end
            size_reg = TSIZE_RESET;
            start_id = FIRST_ID_RESET;
            next_id  = FIRST_ID_RESET;
            expected_resps.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_resps.size() == 0) begin
                    $error("result with no request outstanding: status %0d", m_status);
                    fail_count++;
                end else begin
                    want = expected_resps.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_found_index !== want.found) begin
                        $error("found_index: expected %0d, actual %0d",
                               want.found, m_found_index);
                        fail_count++;
                    end
                    if (m_assigned_id !== want.assigned) begin
                        $error("assigned_id: expected %h, actual %h",
                               want.assigned, m_assigned_id);
                        fail_count++;
                    end
                    if (m_record_out !== want.word) begin
                        $error("record_out: expected %h, actual %h", want.word, m_record_out);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                req.func = s_func;
                req.slot = s_slot_index;
                req.word = s_record_word;
                req.sid  = s_search_id;
                expected_resps.push_back(apply_request(req));
            end
            if (cfg_wr_en) begin
                if (cfg_index == CFG_TABLE_SIZE) begin
                    size_reg = cfg_wdata[TSIZE_W-1:0];
                end else begin
                    // id counter restarts from the new value right away
                    start_id = cfg_wdata[ID_W-1:0];
                    next_id  = start_id;
                end
            end
        end
        pending_count = expected_resps.size();
    end

endmodule

// File: tb/sv/tb_slot_table_with_id_lookup_unit.sv
module tb_slot_table_with_id_lookup_unit;
    import stl_pkg::*;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;

    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func        = FUNC_INSERT;
    logic [SLOT_W-1:0]   s_slot_index  = '0;
    logic [WORD_W-1:0]   s_record_word = '0;
    logic [ID_W-1:0]     s_search_id   = '0;

    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [FOUND_W-1:0]  m_found_index;
    logic [ID_W-1:0]     m_assigned_id;
    logic [WORD_W-1:0]   m_record_out;

    logic                cfg_wr_en     = 1'b0;
    logic                cfg_index     = CFG_TABLE_SIZE;
    logic [CFG_W-1:0]    cfg_wdata     = '0;

    int                  failures;
    int                  outstanding;

    // stimulus-side view of the configuration, used to aim requests
    int                  cur_size  = 64;
    logic [ID_W-1:0]     id_base   = '0;
    int                  ids_given = 0;
    logic                quiet     = 1'b0;

    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 150;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    slot_table_with_id_lookup_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_slot_index  (s_slot_index),
        .s_record_word (s_record_word),
        .s_search_id   (s_search_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .m_assigned_id (m_assigned_id),
        .m_record_out  (m_record_out),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    slot_table_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_slot_index  (s_slot_index),
        .s_record_word (s_record_word),
        .s_search_id   (s_search_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_index (m_found_index),
        .m_assigned_id (m_assigned_id),
        .m_record_out  (m_record_out),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (failures),
        .pending_count (outstanding)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // entered right after a rising edge; returns at the edge that takes the request
    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] idx,
                            input logic [WORD_W-1:0] rec, input logic [ID_W-1:0] sid);
        int g;
        g = gap_len();
        @(negedge aclk);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= f;
        s_slot_index  <= idx;
        s_record_word <= rec;
        s_search_id   <= sid;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_all();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // called with the table idle
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_TABLE_SIZE) begin
            cur_size = int'(value[TSIZE_W-1:0]);
        end else begin
            id_base   = value;
            ids_given = 0;
        end
    endtask

    task automatic random_req();
        logic [FUNC_W-1:0] f;
        logic [SLOT_W-1:0] idx;
        logic [ID_W-1:0]   sid;
        int                lim;
        int                r;
        lim = (cur_size > 64) ? 64 : cur_size;
        r   = $urandom_range(0, 99);
        if (r < 35) begin
            f = FUNC_INSERT;
        end else if (r < 50) begin
            f = FUNC_REMOVE;
        end else if (r < 80) begin
            f = FUNC_FIND_ID;
        end else begin
            f = FUNC_FIND_EMPTY;
        end
        if ($urandom_range(0, 15) == 0) begin
            idx = SLOT_W'($urandom_range(0, 255));
        end else begin
            idx = SLOT_W'($urandom_range(0, lim));
        end
        // aim mostly at recently handed-out ids so lookups hit
        if ($urandom_range(0, 7) == 0) begin
            sid = $urandom;
        end else begin
            sid = id_base + ID_W'(ids_given) - ID_W'($urandom_range(0, 2 * lim + 1));
        end
        if (f == FUNC_INSERT && int'(idx) < lim) begin
            ids_given++;
        end
        send_req(f, idx, {$urandom, $urandom}, sid);
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 7) == 0) begin
                    hold = gap_len();
                end
            end
        end
    end

    initial begin : stimulus
        int sizes[PHASES];
        sizes = '{64, 8, 1, 127, 3, 0, 20, 64};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 64 slots, ids from zero
        send_req(FUNC_FIND_EMPTY, 8'd0,   64'd0, 32'd0);
        send_req(FUNC_FIND_ID,    8'd0,   64'd0, 32'd0);
        send_req(FUNC_INSERT,     8'd0,   64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_req(FUNC_INSERT,     8'd63,  64'd0, 32'hFFFF_FFFF);
        send_req(FUNC_INSERT,     8'd64,  64'h1234, 32'd0);
        send_req(FUNC_INSERT,     8'd255, 64'h5678, 32'd0);
        send_req(FUNC_FIND_ID,    8'd0,   64'd0, 32'd1);
        send_req(FUNC_FIND_ID,    8'd0,   64'd0, 32'd0);
        send_req(FUNC_INSERT,     8'd0,   64'hA5A5_5A5A_0F0F_F0F0, 32'd0);
        send_req(FUNC_FIND_ID,    8'd0,   64'd0, 32'd0);
        send_req(FUNC_REMOVE,     8'd5,   64'd0, 32'd0);
        send_req(FUNC_REMOVE,     8'd0,   64'd0, 32'd0);
        send_req(FUNC_REMOVE,     8'd64,  64'd0, 32'd0);
        send_req(FUNC_FIND_EMPTY, 8'd0,   64'd0, 32'd0);
        send_req(FUNC_FIND_ID,    8'd0,   64'd0, 32'hFFFF_FFFF);

        // two slots, id counter wraps, table fills
        drain_all();
        write_reg(CFG_TABLE_SIZE, 32'd2);
        write_reg(CFG_FIRST_ID, 32'hFFFF_FFFF);
        send_req(FUNC_INSERT,     8'd0, 64'h1, 32'd0);
        send_req(FUNC_INSERT,     8'd1, 64'h2, 32'd0);
        send_req(FUNC_FIND_EMPTY, 8'd0, 64'd0, 32'd0);
        send_req(FUNC_FIND_ID,    8'd0, 64'd0, 32'd0);
        send_req(FUNC_INSERT,     8'd2, 64'h3, 32'd0);

        // no slot in range
        drain_all();
        write_reg(CFG_TABLE_SIZE, 32'd0);
        send_req(FUNC_INSERT,     8'd0, 64'h4, 32'd0);
        send_req(FUNC_REMOVE,     8'd0, 64'd0, 32'd0);
        send_req(FUNC_FIND_ID,    8'd0, 64'd0, 32'hFFFF_FFFF);
        send_req(FUNC_FIND_EMPTY, 8'd0, 64'd0, 32'd0);

        // oversized size acts as the full table
        drain_all();
        write_reg(CFG_TABLE_SIZE, 32'd127);
        send_req(FUNC_INSERT,     8'd63, 64'h5, 32'd0);
        send_req(FUNC_FIND_ID,    8'd0,  64'd0, 32'd0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_all();
            if (ph == PHASES - 1) begin
                sizes[ph] = $urandom_range(1, 64);
            end
            // upper bits of the write data are don't-care for the size register
            write_reg(CFG_TABLE_SIZE, ($urandom & ~32'h7F) | CFG_W'(sizes[ph]));
            if (ph == 0 || ph == 7) begin
                write_reg(CFG_FIRST_ID, $urandom);
            end else if (ph == 3) begin
                write_reg(CFG_FIRST_ID, 32'hFFFF_FFF0);
            end else if (ph == 5) begin
                write_reg(CFG_FIRST_ID, 32'd0);
            end
            quiet = (ph == 2 || ph == 6);
            for (int n = 0; n < PHASE_REQS; n++) begin
                random_req();
            end
        end

        drain_all();
        repeat (150) @(negedge aclk);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: slot_table_with_id_lookup_unit.f
hdl/stl_pkg.sv
hdl/slot_table_with_id_lookup_unit.sv
tb/sv/slot_table_checker.sv
tb/sv/tb_slot_table_with_id_lookup_unit.sv
